// ===== rtl/llc_frame_header_decoder_core_assert.svh =====
// Assertion macros for the LLC header decoder.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef LLC_FRAME_HEADER_DECODER_CORE_ASSERT_SVH
`define LLC_FRAME_HEADER_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LLCHD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("llchd: same-cycle check failed");

// Next-cycle implication.
`define LLCHD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("llchd: next-cycle check failed");

`endif

// ===== rtl/llchd_pkg.sv =====
package llchd_pkg;

  localparam int unsigned SapTableEntries   = 27;
  localparam int unsigned UframeTableEntries = 17;

  localparam logic [4:0] SAP_NOT_FOUND = 5'(SapTableEntries);
  localparam logic [4:0] UMOD_NONE     = 5'(UframeTableEntries);

  // Byte positions within the header.
  localparam logic [4:0] POS_SRC    = 5'd6;
  localparam logic [4:0] POS_LENGTH = 5'd12;
  localparam logic [4:0] POS_DSAP   = 5'd14;
  localparam logic [4:0] POS_SSAP   = 5'd15;
  localparam logic [4:0] POS_CTRL   = 5'd16;
  localparam logic [4:0] POS_CTRL2  = 5'd17;

  typedef enum logic [1:0] {
    KIND_INFO  = 2'd0,
    KIND_SUPER = 2'd1,
    KIND_UNNUM = 2'd2,
    KIND_TRUNC = 2'd3
  } llchd_kind_e;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
    logic [15:0] length_field;
    logic [4:0]  dsap_code;
    logic        dsap_group;
    logic [4:0]  ssap_code;
    logic        ssap_response;
    llchd_kind_e frame_kind;
    logic [6:0]  send_seq;
    logic [6:0]  recv_seq;
    logic        poll_final;
    logic [4:0]  function_code;
  } llchd_report_t;

  localparam logic [7:0] SAP_LIST [SapTableEntries] = '{
    8'h00, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h08, 8'h0c, 8'h0e, 8'h18, 8'h42, 8'h4e,
    8'h7e, 8'h80, 8'h86, 8'h8e, 8'h98, 8'hbc, 8'haa, 8'he0, 8'hf0, 8'hf4, 8'hf5, 8'hf8,
    8'hfa, 8'hfe, 8'hff
  };

  // Modifier key is control bits {7,6,5,3,2}.
  localparam logic [4:0] UMOD_LIST [UframeTableEntries] = '{
    5'd16, 5'd27, 5'd3, 5'd11, 5'd7, 5'd15, 5'd1, 5'd8, 5'd12, 5'd3, 5'd8, 5'd1,
    5'd0, 5'd4, 5'd19, 5'd23, 5'd28
  };

  // First exact match wins; failing that, the first match with bit 0 cleared.
  function automatic logic [4:0] sap_find(input logic [7:0] v);
    logic [4:0] code;
    code = SAP_NOT_FOUND;
    for (int i = SapTableEntries - 1; i >= 0; i--) begin
      if (SAP_LIST[i] == {v[7:1], 1'b0}) code = 5'(i);
    end
    for (int i = SapTableEntries - 1; i >= 0; i--) begin
      if (SAP_LIST[i] == v) code = 5'(i);
    end
    return code;
  endfunction

  // The last matching table entry wins.
  function automatic logic [4:0] umod_find(input logic [7:0] c);
    logic [4:0] code;
    logic [4:0] key;
    code = UMOD_NONE;
    key  = {c[7:5], c[3:2]};
    for (int i = 0; i < UframeTableEntries; i++) begin
      if (UMOD_LIST[i] == key) code = 5'(i);
    end
    return code;
  endfunction

endpackage

// ===== rtl/llchd_if.sv =====
interface llchd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       start_of_frame;
  logic       end_of_frame;

  modport source (output valid, frame_byte, start_of_frame, end_of_frame, input ready);
  modport sink   (input valid, frame_byte, start_of_frame, end_of_frame, output ready);
endinterface

interface llchd_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] dest_mac;
  logic [47:0] src_mac;
  logic [15:0] length_field;
  logic [4:0]  dsap_code;
  logic        dsap_group;
  logic [4:0]  ssap_code;
  logic        ssap_response;
  logic [1:0]  frame_kind;
  logic [6:0]  send_seq;
  logic [6:0]  recv_seq;
  logic        poll_final;
  logic [4:0]  function_code;

  modport source (output valid, dest_mac, src_mac, length_field, dsap_code, dsap_group,
                  ssap_code, ssap_response, frame_kind, send_seq, recv_seq, poll_final,
                  function_code, input ready);
  modport sink   (input valid, dest_mac, src_mac, length_field, dsap_code, dsap_group,
                  ssap_code, ssap_response, frame_kind, send_seq, recv_seq, poll_final,
                  function_code, output ready);
endinterface

// ===== rtl/llc_frame_header_decoder_core.sv =====
// LLC header decoder. The in_i channel carries one frame byte per word, with
// start_of_frame on the first byte and end_of_frame on the last. The out_o
// channel carries at most one header report word per frame: MAC addresses,
// length, SAP table indices and the decoded control field.
// A report reaches the output register in the cycle after the byte that
// completes it (control byte 16 for unnumbered frames, byte 17 for information
// and supervisory frames, or an early end_of_frame, reported as truncated).
// Throughput: one byte per cycle while the output register can take a report;
// position counter, field capture and table lookups are all combinational.
// Bytes that arrive after a report and before the next start_of_frame are
// taken and dropped. A start_of_frame always restarts capture.
// Reset puts the decoder idle, waiting for a start_of_frame, with the output
// register empty. When the receiver stalls, the report waits in the output
// register and input words are refused only while that register is full and
// out_o.ready is low.
`include "llc_frame_header_decoder_core_assert.svh"

module llc_frame_header_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  llchd_in_if.sink    in_i,
  llchd_out_if.source out_o
);

  // Header capture state.
  logic [4:0]  pos_q, pos_d;
  logic        done_q, done_d;
  logic [47:0] dest_q, dest_d;
  logic [47:0] src_q, src_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  dsap_q, dsap_d;
  logic [7:0]  ssap_q, ssap_d;
  logic [7:0]  ctrl_q, ctrl_d;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  llchd_pkg::llchd_report_t rep_q, rep_d;

  logic in_fire;
  logic emit;

  // A new byte is taken whenever the output register is free or being emptied.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    logic [4:0] p;
    logic [7:0] b;
    pos_d  = pos_q;
    done_d = done_q;
    dest_d = dest_q;
    src_d  = src_q;
    len_d  = len_q;
    dsap_d = dsap_q;
    ssap_d = ssap_q;
    ctrl_d = ctrl_q;
    rep_d  = rep_q;
    emit   = 1'b0;
    p      = '0;
    b      = in_i.frame_byte;

    if (in_fire) begin
      // A start of frame wipes the capture; it does not touch the output register.
      if (in_i.start_of_frame) begin
        pos_d  = '0;
        done_d = 1'b0;
        dest_d = '0;
        src_d  = '0;
        len_d  = '0;
        dsap_d = '0;
        ssap_d = '0;
        ctrl_d = '0;
      end

      if (!done_d) begin
        p = pos_d;
        priority if (p < llchd_pkg::POS_SRC) begin
          dest_d = {dest_d[39:0], b};
        end else if (p < llchd_pkg::POS_LENGTH) begin
          src_d = {src_d[39:0], b};
        end else if (p < llchd_pkg::POS_DSAP) begin
          len_d = {len_d[7:0], b};
        end else if (p == llchd_pkg::POS_DSAP) begin
          dsap_d = b;
        end else if (p == llchd_pkg::POS_SSAP) begin
          ssap_d = b;
        end else if (p == llchd_pkg::POS_CTRL) begin
          ctrl_d = b;
        end else begin
          // Second control byte is used directly, not stored.
        end
        if (p < llchd_pkg::POS_CTRL2) pos_d = p + 5'd1;

        rep_d.send_seq      = '0;
        rep_d.recv_seq      = '0;
        rep_d.poll_final    = 1'b0;
        rep_d.function_code = '0;
        rep_d.frame_kind    = llchd_pkg::KIND_TRUNC;

        priority if (p == llchd_pkg::POS_CTRL && b[1:0] == 2'b11) begin
          emit                = 1'b1;
          rep_d.frame_kind    = llchd_pkg::KIND_UNNUM;
          rep_d.poll_final    = b[4];
          rep_d.function_code = llchd_pkg::umod_find(b);
        end else if (p >= llchd_pkg::POS_CTRL2) begin
          emit = 1'b1;
          if (!ctrl_d[0]) begin
            rep_d.frame_kind = llchd_pkg::KIND_INFO;
            rep_d.send_seq   = ctrl_d[7:1];
          end else begin
            rep_d.frame_kind    = llchd_pkg::KIND_SUPER;
            rep_d.function_code = {3'b000, ctrl_d[3:2]};
          end
          rep_d.recv_seq   = b[7:1];
          rep_d.poll_final = b[0];
        end else if (in_i.end_of_frame) begin
          emit = 1'b1;
        end else begin
          emit = 1'b0;
        end

        if (emit) begin
          done_d             = 1'b1;
          rep_d.dest_mac     = dest_d;
          rep_d.src_mac      = src_d;
          rep_d.length_field = len_d;
          if (p >= llchd_pkg::POS_DSAP) begin
            rep_d.dsap_code  = llchd_pkg::sap_find(dsap_d);
            rep_d.dsap_group = dsap_d[0];
          end else begin
            rep_d.dsap_code  = llchd_pkg::SAP_NOT_FOUND;
            rep_d.dsap_group = 1'b0;
          end
          if (p >= llchd_pkg::POS_SSAP) begin
            rep_d.ssap_code     = llchd_pkg::sap_find(ssap_d);
            rep_d.ssap_response = ssap_d[0];
          end else begin
            rep_d.ssap_code     = llchd_pkg::SAP_NOT_FOUND;
            rep_d.ssap_response = 1'b0;
          end
        end else begin
          rep_d = rep_q;
        end
      end
    end

    out_valid_d = emit || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      done_q      <= 1'b1;
      dest_q      <= '0;
      src_q       <= '0;
      len_q       <= '0;
      dsap_q      <= '0;
      ssap_q      <= '0;
      ctrl_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      done_q      <= done_d;
      dest_q      <= dest_d;
      src_q       <= src_d;
      len_q       <= len_d;
      dsap_q      <= dsap_d;
      ssap_q      <= ssap_d;
      ctrl_q      <= ctrl_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The report register needs no reset; it is only read while valid.
  always_ff @(posedge clk_i) begin
    rep_q <= rep_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.dest_mac      = rep_q.dest_mac;
  assign out_o.src_mac       = rep_q.src_mac;
  assign out_o.length_field  = rep_q.length_field;
  assign out_o.dsap_code     = rep_q.dsap_code;
  assign out_o.dsap_group    = rep_q.dsap_group;
  assign out_o.ssap_code     = rep_q.ssap_code;
  assign out_o.ssap_response = rep_q.ssap_response;
  assign out_o.frame_kind    = rep_q.frame_kind;
  assign out_o.send_seq      = rep_q.send_seq;
  assign out_o.recv_seq      = rep_q.recv_seq;
  assign out_o.poll_final    = rep_q.poll_final;
  assign out_o.function_code = rep_q.function_code;

  // The position counter never runs past the second control byte.
  `LLCHD_ASSERT_NOW(a_pos_bound, 1'b1, pos_q <= llchd_pkg::POS_CTRL2)
  // Every report closes its frame: the decoder goes idle with a full output register.
  `LLCHD_ASSERT_NEXT(a_emit_idle, emit, done_q && out_valid_q)
  // A truncated report never carries control field contents.
  `LLCHD_ASSERT_NOW(a_trunc_clean,
                    out_valid_q && rep_q.frame_kind == llchd_pkg::KIND_TRUNC,
                    rep_q.send_seq == '0 && rep_q.recv_seq == '0 && !rep_q.poll_final)

endmodule

// ===== tb/llc_frame_header_decoder_core_checker.sv =====
// Watches both channels of the LLC header decoder, keeps its own copy of the
// header capture state and compares every report word with the prediction.
module llc_frame_header_decoder_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  llchd_in_if         in_i,
  llchd_out_if        out_i,
  output int unsigned error_count_o,
  output int unsigned reports_pending_o,
  output int unsigned reports_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] KNOWN_SAPS [llchd_pkg::SapTableEntries] = '{
    8'h00, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h08, 8'h0c, 8'h0e, 8'h18, 8'h42, 8'h4e,
    8'h7e, 8'h80, 8'h86, 8'h8e, 8'h98, 8'hbc, 8'haa, 8'he0, 8'hf0, 8'hf4, 8'hf5, 8'hf8,
    8'hfa, 8'hfe, 8'hff
  };

  // Keys are built from control bits 7, 6, 5, 3 and 2.
  localparam logic [4:0] MODIFIER_KEYS [llchd_pkg::UframeTableEntries] = '{
    5'd16, 5'd27, 5'd3, 5'd11, 5'd7, 5'd15, 5'd1, 5'd8, 5'd12, 5'd3, 5'd8, 5'd1,
    5'd0, 5'd4, 5'd19, 5'd23, 5'd28
  };

  logic [4:0]               hdr_pos;
  logic                     hdr_idle;
  logic [47:0]              dest_acc;
  logic [47:0]              src_acc;
  logic [15:0]              len_acc;
  logic [7:0]               dsap_byte;
  logic [7:0]               ssap_byte;
  logic [7:0]               ctrl_byte;
  llchd_pkg::llchd_report_t report_q[$];
  int unsigned              errors = 0;
  int unsigned              checked = 0;
  int unsigned              pending = 0;

  assign error_count_o     = errors;
  assign reports_pending_o = pending;
  assign reports_checked_o = checked;

  function automatic logic [4:0] sap_index(input logic [7:0] sap);
    for (int i = 0; i < llchd_pkg::SapTableEntries; i++)
      if (KNOWN_SAPS[i] == sap) return 5'(i);
    for (int i = 0; i < llchd_pkg::SapTableEntries; i++)
      if (KNOWN_SAPS[i] == {sap[7:1], 1'b0}) return 5'(i);
    return llchd_pkg::SAP_NOT_FOUND;
  endfunction

  function automatic logic [4:0] modifier_index(input logic [7:0] ctrl);
    logic [4:0] idx;
    idx = llchd_pkg::UMOD_NONE;
    for (int i = 0; i < llchd_pkg::UframeTableEntries; i++)
      if (MODIFIER_KEYS[i] == {ctrl[7:5], ctrl[3:2]}) idx = 5'(i);
    return idx;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic sof, input logic eof);
    logic [4:0]               pos;
    llchd_pkg::llchd_report_t rpt;
    bit                       emit;
    if (sof) begin
      hdr_pos   = '0;
      hdr_idle  = 1'b0;
      dest_acc  = '0;
      src_acc   = '0;
      len_acc   = '0;
      dsap_byte = '0;
      ssap_byte = '0;
      ctrl_byte = '0;
    end
    if (hdr_idle) return;
    pos  = hdr_pos;
    rpt  = '0;
    emit = 1'b1;
    if (pos < llchd_pkg::POS_SRC) dest_acc = {dest_acc[39:0], b};
    else if (pos < llchd_pkg::POS_LENGTH) src_acc = {src_acc[39:0], b};
    else if (pos < llchd_pkg::POS_DSAP) len_acc = {len_acc[7:0], b};
    else if (pos == llchd_pkg::POS_DSAP) dsap_byte = b;
    else if (pos == llchd_pkg::POS_SSAP) ssap_byte = b;
    else if (pos == llchd_pkg::POS_CTRL) ctrl_byte = b;
    if (pos < llchd_pkg::POS_CTRL2) hdr_pos = pos + 5'd1;

    if (pos == llchd_pkg::POS_CTRL && b[1:0] == 2'b11) begin
      rpt.frame_kind    = llchd_pkg::KIND_UNNUM;
      rpt.poll_final    = b[4];
      rpt.function_code = modifier_index(b);
    end else if (pos >= llchd_pkg::POS_CTRL2) begin
      if (!ctrl_byte[0]) begin
        rpt.frame_kind = llchd_pkg::KIND_INFO;
        rpt.send_seq   = ctrl_byte[7:1];
      end else begin
        rpt.frame_kind    = llchd_pkg::KIND_SUPER;
        rpt.function_code = {3'b000, ctrl_byte[3:2]};
      end
      rpt.recv_seq   = b[7:1];
      rpt.poll_final = b[0];
    end else if (eof) begin
      rpt.frame_kind = llchd_pkg::KIND_TRUNC;
    end else begin
      emit = 1'b0;
    end

    if (emit) begin
      hdr_idle          = 1'b1;
      rpt.dest_mac      = dest_acc;
      rpt.src_mac       = src_acc;
      rpt.length_field  = len_acc;
      rpt.dsap_code     = (pos >= llchd_pkg::POS_DSAP) ? sap_index(dsap_byte)
                                                       : llchd_pkg::SAP_NOT_FOUND;
      rpt.dsap_group    = (pos >= llchd_pkg::POS_DSAP) && dsap_byte[0];
      rpt.ssap_code     = (pos >= llchd_pkg::POS_SSAP) ? sap_index(ssap_byte)
                                                       : llchd_pkg::SAP_NOT_FOUND;
      rpt.ssap_response = (pos >= llchd_pkg::POS_SSAP) && ssap_byte[0];
      report_q.push_back(rpt);
    end
  endtask

  function automatic int unsigned field_diff(input string name, input logic [47:0] want,
                                             input logic [47:0] got);
    if (got !== want) begin
      $error("report field %s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_report();
    llchd_pkg::llchd_report_t want;
    if (report_q.size() == 0) begin
      $error("report word with no report expected (frame_kind 0x%0h)", out_i.frame_kind);
      errors++;
      return;
    end
    want = report_q.pop_front();
    checked++;
    errors += field_diff("dest_mac", want.dest_mac, out_i.dest_mac);
    errors += field_diff("src_mac", want.src_mac, out_i.src_mac);
    errors += field_diff("length_field", 48'(want.length_field), 48'(out_i.length_field));
    errors += field_diff("dsap_code", 48'(want.dsap_code), 48'(out_i.dsap_code));
    errors += field_diff("dsap_group", 48'(want.dsap_group), 48'(out_i.dsap_group));
    errors += field_diff("ssap_code", 48'(want.ssap_code), 48'(out_i.ssap_code));
    errors += field_diff("ssap_response", 48'(want.ssap_response),
                         48'(out_i.ssap_response));
    errors += field_diff("frame_kind", 48'(want.frame_kind), 48'(out_i.frame_kind));
    errors += field_diff("send_seq", 48'(want.send_seq), 48'(out_i.send_seq));
    errors += field_diff("recv_seq", 48'(want.recv_seq), 48'(out_i.recv_seq));
    errors += field_diff("poll_final", 48'(want.poll_final), 48'(out_i.poll_final));
    errors += field_diff("function_code", 48'(want.function_code),
                         48'(out_i.function_code));
  endtask

  // A report reaches the output register in the cycle after its byte, so the
  // output side is handled before the byte accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos   = '0;
      hdr_idle  = 1'b1;
      dest_acc  = '0;
      src_acc   = '0;
      len_acc   = '0;
      dsap_byte = '0;
      ssap_byte = '0;
      ctrl_byte = '0;
      report_q.delete();
      pending   = 0;
    end else begin
      if (out_i.valid && out_i.ready) check_report();
      if (in_i.valid && in_i.ready)
        decode_byte(in_i.frame_byte, in_i.start_of_frame, in_i.end_of_frame);
      pending = report_q.size();
    end
  end

endmodule

// ===== tb/llc_frame_header_decoder_core_tb.sv =====
module llc_frame_header_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Stimulus volume: the run stops starting new frames once this many input
  // words have been sent, counting every byte, payload and noise included.
  localparam int unsigned InputBytes  = 450;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned HeaderBytes = 18;
  localparam int unsigned PauseFrame  = 12;

  // Shapes of random frames: complete information, supervisory and
  // unnumbered headers, headers cut short by end_of_frame, headers cut short
  // by a new start_of_frame, and stray bytes outside any frame.
  typedef enum int unsigned {
    SHAPE_INFO,
    SHAPE_SUPER,
    SHAPE_UNNUM,
    SHAPE_TRUNC,
    SHAPE_ABANDON,
    SHAPE_NOISE
  } frame_shape_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          quiet;
  logic [7:0]  frame_buf[$];
  int unsigned bytes_sent;
  int unsigned frames_sent;
  int unsigned shape_tally[SHAPE_NOISE + 1];
  int unsigned error_count;
  int unsigned reports_pending;
  int unsigned reports_checked;

  llchd_in_if  in_bus ();
  llchd_out_if out_bus ();

  llc_frame_header_decoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  llc_frame_header_decoder_core_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_i              (in_bus),
    .out_i             (out_bus),
    .error_count_o     (error_count),
    .reports_pending_o (reports_pending),
    .reports_checked_o (reports_checked)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Length of an idle stretch: mostly none, sometimes a few cycles, and now
  // and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // SAP byte: usually a table entry, sometimes a table entry with bit 0
  // flipped (which exercises the cleared-low-bit lookup), otherwise random.
  function automatic logic [7:0] pick_sap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return llchd_pkg::SAP_LIST[$urandom_range(0, llchd_pkg::SapTableEntries - 1)];
    if (r < 7) begin
      return llchd_pkg::SAP_LIST[$urandom_range(0, llchd_pkg::SapTableEntries - 1)] ^ 8'h01;
    end
    return 8'($urandom);
  endfunction

  // Puts one word on the input channel at the falling edge, after an
  // optional gap, and holds it until the decoder takes it.
  task automatic send_byte(input logic [7:0] b, input logic sof, input logic eof);
    int unsigned gap;
    gap = quiet ? 0 : idle_len();
    if (gap != 0) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_bus.valid          <= 1'b1;
    in_bus.frame_byte     <= b;
    in_bus.start_of_frame <= sof;
    in_bus.end_of_frame   <= eof;
    do @(posedge clk_i); while (!in_bus.ready);
    bytes_sent++;
  endtask

  // Sends frame_buf as one frame; end_of_frame goes on the last byte only
  // when the frame is closed, otherwise the next start_of_frame cuts it off.
  task automatic send_frame(input bit close);
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == 0, close && (i == frame_buf.size() - 1));
    end
  endtask

  // Holds the input channel idle until every predicted report has come out.
  task automatic drain_reports();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (reports_pending != 0) @(negedge clk_i);
  endtask

  // Builds the full 18-byte header for a shape. Truncated and abandoned
  // frames get a control byte that never marks an unnumbered frame, so the
  // cut decides what happens to them.
  task automatic fill_header(input frame_shape_e shape);
    int unsigned dest_style;
    int unsigned src_style;
    int unsigned style;
    logic [7:0]  ctrl;
    logic [4:0]  key;
    frame_buf.delete();
    dest_style = $urandom_range(0, 9);
    src_style  = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) begin
      style = (i < 6) ? dest_style : src_style;
      frame_buf.push_back(style == 0 ? 8'h00 : style == 1 ? 8'hff : 8'($urandom));
    end
    frame_buf.push_back(8'($urandom));
    frame_buf.push_back(8'($urandom));
    frame_buf.push_back(pick_sap());
    frame_buf.push_back(pick_sap());
    case (shape)
      SHAPE_INFO: begin
        ctrl = {7'($urandom), 1'b0};
      end
      SHAPE_SUPER: begin
        ctrl = {6'($urandom), 2'b01};
      end
      SHAPE_UNNUM: begin
        if ($urandom_range(0, 4) != 0) begin
          key  = llchd_pkg::UMOD_LIST[$urandom_range(0, llchd_pkg::UframeTableEntries - 1)];
          ctrl = {key[4:2], 1'($urandom), key[1:0], 2'b11};
        end else begin
          ctrl = {6'($urandom), 2'b11};
        end
      end
      default: begin
        ctrl = 8'($urandom);
        if (ctrl[1:0] == 2'b11) ctrl[1] = 1'b0;
      end
    endcase
    frame_buf.push_back(ctrl);
    frame_buf.push_back(8'($urandom));
  endtask

  // Output side: ready drops for random stretches, except while the
  // stimulus asks for a quiet frame.
  initial begin : report_sink
    int unsigned hold;
    hold = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni || hold != 0) begin
        out_bus.ready <= 1'b0;
        if (hold != 0) hold--;
      end else begin
        out_bus.ready <= 1'b1;
        if (!quiet) hold = idle_len();
      end
    end
  end

  initial begin : stimulus
    frame_shape_e shape;
    int unsigned  pick;
    int unsigned  cut;
    rst_ni                = 1'b0;
    quiet                 = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.frame_byte     = 8'h00;
    in_bus.start_of_frame = 1'b0;
    in_bus.end_of_frame   = 1'b0;
    bytes_sent            = 0;
    frames_sent           = 0;
    foreach (shape_tally[i]) shape_tally[i] = 0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. A stray byte carrying end_of_frame right after reset
    // must be dropped. A frame that starts and ends on the same byte gives a
    // truncated report with nothing captured but that byte.
    send_byte(8'ha5, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    // A frame cut short by the next start_of_frame produces nothing; the
    // all-ones frame after it is unnumbered with no modifier match and both
    // SAPs at the last table entry.
    frame_buf = '{8'h00, 8'h00, 8'h00};
    send_frame(1'b0);
    frame_buf.delete();
    repeat (17) frame_buf.push_back(8'hff);
    send_frame(1'b1);
    drain_reports();

    // Random part. Mostly complete headers with random content, some cut
    // short either way, and a little noise between frames.
    while (bytes_sent < InputBytes) begin
      pick  = $urandom_range(0, 99);
      shape = pick < 24 ? SHAPE_INFO  : pick < 44 ? SHAPE_SUPER :
              pick < 68 ? SHAPE_UNNUM : pick < 84 ? SHAPE_TRUNC :
              pick < 94 ? SHAPE_ABANDON : SHAPE_NOISE;
      quiet = ($urandom_range(0, 5) == 0);
      shape_tally[shape]++;
      fill_header(shape);
      case (shape)
        SHAPE_INFO, SHAPE_SUPER, SHAPE_UNNUM: begin
          // Unnumbered headers end at the first control byte. Trailing
          // payload bytes follow the report and must be ignored.
          if (shape == SHAPE_UNNUM) void'(frame_buf.pop_back());
          repeat ($urandom_range(0, 3)) frame_buf.push_back(8'($urandom));
          send_frame(1'b1);
        end
        SHAPE_TRUNC, SHAPE_ABANDON: begin
          cut = $urandom_range(1, HeaderBytes - 1);
          while (frame_buf.size() > cut) void'(frame_buf.pop_back());
          send_frame(shape == SHAPE_TRUNC);
        end
        default: begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom));
        end
      endcase
      if (shape != SHAPE_NOISE) begin
        frames_sent++;
        // Once mid-run the sender holds off until the output side is empty.
        if (frames_sent == PauseFrame) drain_reports();
      end
    end
    quiet = 1'b0;

    drain_reports();
    repeat (DrainCycles) @(negedge clk_i);

    $display("Directed frames plus %0d random frames (%0d info, %0d supervisory,",
             frames_sent, shape_tally[SHAPE_INFO], shape_tally[SHAPE_SUPER]);
    $display("  %0d unnumbered, %0d ended early, %0d restarted); %0d reports checked.",
             shape_tally[SHAPE_UNNUM], shape_tally[SHAPE_TRUNC],
             shape_tally[SHAPE_ABANDON], reports_checked);
    if (error_count == 0 && reports_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== llc_frame_header_decoder_core.f =====
+incdir+rtl
rtl/llchd_pkg.sv
rtl/llchd_if.sv
rtl/llc_frame_header_decoder_core.sv
tb/llc_frame_header_decoder_core_checker.sv
tb/llc_frame_header_decoder_core_tb.sv
